// File: src/tast_pkg.sv
// ----------------------------------------------------------------------------
// tast_pkg
// shared types and constants of the tagged address slot translator
// ----------------------------------------------------------------------------
package tast_pkg;

    localparam int MAX_GROUPS = 4;
    localparam int MAX_SLOTS  = 16;
    localparam int DEPTH      = MAX_GROUPS * MAX_SLOTS;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADDR_W     = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_BITS = 2'd3;

    localparam logic [2:0] CMD_TRANSLATE = 3'd0;
    localparam logic [2:0] CMD_ADD       = 3'd1;
    localparam logic [2:0] CMD_DELETE    = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_SIZE      = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_GROUP = 3'd1;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd2;
    localparam logic [2:0] ST_BAD_GEN   = 3'd3;
    localparam logic [2:0] ST_WRAP      = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;

    typedef struct packed {
        logic [2:0]        command;
        logic [7:0]        group_index;
        logic [7:0]        slot_index;
        logic [ADDR_W-1:0] address;
        logic [31:0]       access_size;
        logic [ADDR_W-1:0] offset_value;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic [31:0]       slot_generation;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] result_value;
    } t_out_item;

    typedef struct packed {
        logic [2:0] groups;
        logic [4:0] slots;
        logic [3:0] id_bits;
        logic [5:0] gen_bits;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] offset_value;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic [31:0]       slot_generation;
    } t_slot;

    typedef struct packed {
        logic             add;
        logic             del;
        logic             clr;
        logic             rd;
        logic [IDX_W-1:0] idx;
        t_slot            data;
    } t_tbl_req;

endpackage

// File: src/tagged_address_slot_translator_unit.sv
// ----------------------------------------------------------------------------
// tagged_address_slot_translator_unit
// base and bounds translation of tagged addresses over a table of slots
//
// the result strobe rises as the state machine leaves S_OUT
// no new command is taken until S_OUT is done; busy covers the table read and
// the three arithmetic steps after it (offset add, size add, bound subtract)
// reset: synchronous; clears control state and valid bits, presets the config
// the receiver cannot stall; clear all acts through the valid bits
// ----------------------------------------------------------------------------
module tagged_address_slot_translator_unit
    import tast_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_strobe,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOC  = 5'b00010,
        S_ADD  = 5'b00100,
        S_CHK  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [2:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_maddr;
    logic [31:0]       r_tgen;
    logic [ADDR_W-1:0] r_h;
    logic [ADDR_W:0]   r_top;
    logic              r_lt;
    logic              r_strobe;
    t_out_item         r_result, n_result;

    t_cfg              cfg;
    t_tbl_req          req;
    t_slot             slot;

    logic [7:0]        tag_slot;
    logic [6:0]        gen_sh;
    logic [6:0]        tag_w;
    logic [ADDR_W-1:0] addr_sh;
    logic [31:0]       tag_gen;
    logic [ADDR_W-1:0] maddr;
    logic [7:0]        loc_slot;
    logic [2:0]        loc_status;
    logic              is_xlat;
    logic [ADDR_W-1:0] cmp_src;
    logic [ADDR_W-1:0] bnd_src;
    logic [ADDR_W:0]   diff;

    tast_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tast_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_slot  (slot)
    );

    assign is_xlat = (r_item.command == CMD_TRANSLATE);

    // tag extraction and slot lookup
    always_comb begin
        tag_slot = r_item.address[ADDR_W-1:ADDR_W-8] >> (4'd8 - cfg.id_bits);
        tag_w    = 7'(cfg.id_bits) + 7'(cfg.gen_bits);
        gen_sh   = 7'(ADDR_W) - tag_w;
        addr_sh  = r_item.address >> gen_sh;
        tag_gen  = addr_sh[31:0] & (32'hFFFF_FFFF >> (6'd32 - cfg.gen_bits));
        maddr    = r_item.address & ({ADDR_W{1'b1}} >> tag_w);
        loc_slot = is_xlat ? tag_slot : r_item.slot_index;
        priority if (r_item.group_index >= 8'(cfg.groups)) begin
            loc_status = ST_BAD_GROUP;
        end else if (loc_slot >= 8'(cfg.slots)) begin
            loc_status = ST_BAD_SLOT;
        end else begin
            loc_status = ST_OK;
        end
    end

    always_comb begin
        req      = '0;
        req.idx  = IDX_W'(16'(r_item.group_index) * 16'(MAX_SLOTS) + 16'(loc_slot));
        req.data = '{offset_value:    r_item.offset_value,
                     range_start:     r_item.range_start,
                     range_end:       r_item.range_end,
                     slot_generation: r_item.slot_generation};
        if (r_state == S_LOC) begin
            req.rd  = 1'b1;
            req.add = (r_item.command == CMD_ADD) && (loc_status == ST_OK);
            req.del = (r_item.command == CMD_DELETE) && (loc_status == ST_OK);
            req.clr = (r_item.command == CMD_CLEAR);
        end
    end

    // bound checks
    assign cmp_src = is_xlat ? r_h : r_item.address;
    assign bnd_src = is_xlat ? r_top[ADDR_W-1:0] : r_item.address;
    assign diff    = {1'b0, slot.range_end} - {1'b0, bnd_src};

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOC;
                end
            end
            S_LOC: begin
                n_state = S_ADD;
                if (is_xlat || r_item.command == CMD_ADD || r_item.command == CMD_DELETE
                        || r_item.command == CMD_SIZE) begin
                    n_status = loc_status;
                end else begin
                    n_status = ST_OK;
                end
            end
            S_ADD: begin
                n_state = S_CHK;
                if (is_xlat && r_status == ST_OK && r_tgen != slot.slot_generation) begin
                    n_status = ST_BAD_GEN;
                end
            end
            S_CHK: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state  = S_IDLE;
                n_result = '0;
                n_result.status = r_status;
                if (r_status == ST_OK) begin
                    if (is_xlat) begin
                        priority if (r_top[ADDR_W]) begin
                            n_result.status = ST_WRAP;
                        end else if (r_lt || diff[ADDR_W]) begin
                            n_result.status = ST_RANGE;
                        end else begin
                            n_result.result_value = r_h;
                        end
                    end else if (r_item.command == CMD_SIZE) begin
                        if (r_lt || diff[ADDR_W]) begin
                            n_result.status = ST_RANGE;
                        end else begin
                            n_result.result_value = diff[ADDR_W-1:0];
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_result <= n_result;
        if (r_state == S_IDLE && start) begin
            r_item <= i_item;
        end
        if (r_state == S_LOC) begin
            r_maddr <= maddr;
            r_tgen  <= tag_gen;
        end
        if (r_state == S_ADD) begin
            r_h <= r_maddr + slot.offset_value;
        end
        if (r_state == S_CHK) begin
            r_top <= {1'b0, r_h} + {{(ADDR_W-31){1'b0}}, r_item.access_size};
            r_lt  <= cmp_src < slot.range_start;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: src/tast_ram.sv
// ----------------------------------------------------------------------------
// tast_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module tast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tast_cfg.sv
// ----------------------------------------------------------------------------
// tast_cfg
// configuration registers with saturation of out of range settings
// ----------------------------------------------------------------------------
module tast_cfg
    import tast_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [2:0] r_groups;
    logic [4:0] r_slots;
    logic [3:0] r_id_bits;
    logic [5:0] r_gen_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups   <= 3'd1;
            r_slots    <= 5'd1;
            r_id_bits  <= 4'd1;
            r_gen_bits <= 6'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GROUPS:   r_groups   <= i_cfg_data[2:0];
                CFG_SLOTS:    r_slots    <= i_cfg_data[4:0];
                CFG_ID_BITS:  r_id_bits  <= i_cfg_data[3:0];
                CFG_GEN_BITS: r_gen_bits <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg = '0;
        priority if (r_groups == 3'd0) begin
            o_cfg.groups = 3'd1;
        end else if (32'(r_groups) > MAX_GROUPS) begin
            o_cfg.groups = 3'(MAX_GROUPS);
        end else begin
            o_cfg.groups = r_groups;
        end
        priority if (r_slots == 5'd0) begin
            o_cfg.slots = 5'd1;
        end else if (32'(r_slots) > MAX_SLOTS) begin
            o_cfg.slots = 5'(MAX_SLOTS);
        end else begin
            o_cfg.slots = r_slots;
        end
        priority if (r_id_bits == 4'd0) begin
            o_cfg.id_bits = 4'd1;
        end else if (r_id_bits > 4'd8) begin
            o_cfg.id_bits = 4'd8;
        end else begin
            o_cfg.id_bits = r_id_bits;
        end
        priority if (r_gen_bits == 6'd0) begin
            o_cfg.gen_bits = 6'd1;
        end else if (r_gen_bits > 6'd32) begin
            o_cfg.gen_bits = 6'd32;
        end else begin
            o_cfg.gen_bits = r_gen_bits;
        end
    end

    assign o_cfg_ready = 1'b1;

endmodule

// File: src/tast_table.sv
// ----------------------------------------------------------------------------
// tast_table
// slot table in two rams with per entry valid bits, invalid entries read zero
// ----------------------------------------------------------------------------
module tast_table
    import tast_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_slot    o_slot
);

    localparam int A_W = ADDR_W + 32;
    localparam int B_W = 2 * ADDR_W;

    logic [DEPTH-1:0] r_valid_a;
    logic [DEPTH-1:0] r_valid_b;
    logic             r_rd_va;
    logic             r_rd_vb;
    logic [A_W-1:0]   rd_a;
    logic [B_W-1:0]   rd_b;
    logic [B_W-1:0]   wdata_b;

    // offset and generation
    tast_ram #(.WIDTH(A_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_req.add),
        .i_waddr (i_req.idx),
        .i_wdata ({i_req.data.offset_value, i_req.data.slot_generation}),
        .i_re    (i_req.rd),
        .i_raddr (i_req.idx),
        .o_rdata (rd_a)
    );

    // start and end, zeroed by delete
    assign wdata_b = i_req.add ? {i_req.data.range_start, i_req.data.range_end} : '0;

    tast_ram #(.WIDTH(B_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_req.add | i_req.del),
        .i_waddr (i_req.idx),
        .i_wdata (wdata_b),
        .i_re    (i_req.rd),
        .i_raddr (i_req.idx),
        .o_rdata (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= '0;
            r_valid_b <= '0;
            r_rd_va   <= 1'b0;
            r_rd_vb   <= 1'b0;
        end else begin
            if (i_req.rd) begin
                r_rd_va <= r_valid_a[i_req.idx];
                r_rd_vb <= r_valid_b[i_req.idx];
            end
            priority if (i_req.clr) begin
                r_valid_a <= '0;
                r_valid_b <= '0;
            end else if (i_req.add) begin
                r_valid_a[i_req.idx] <= 1'b1;
                r_valid_b[i_req.idx] <= 1'b1;
            end else if (i_req.del) begin
                r_valid_b[i_req.idx] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_slot = '0;
        if (r_rd_va) begin
            o_slot.offset_value    = rd_a[A_W-1:32];
            o_slot.slot_generation = rd_a[31:0];
        end
        if (r_rd_vb) begin
            o_slot.range_start = rd_b[B_W-1:ADDR_W];
            o_slot.range_end   = rd_b[ADDR_W-1:0];
        end
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tagged address slot translator
//
// drives commands through the start/busy port and keeps its own copy of the
// slot table and the configuration, from which the status and value of
// every command are worked out when the command is accepted. each strobed
// result is compared with the oldest outstanding prediction. directed tests
// cover the reset settings, every command and every error path; random
// traffic then runs under several register settings, extremes included, with
// the sender in bursts separated by random gaps, and in one phase gapless.
// ----------------------------------------------------------------------------
module tb_top;
    import tast_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 102;
    localparam logic [63:0] ALL_ONES      = '1;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in_item              i_item      = '0;
    logic                  o_strobe;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    tagged_address_slot_translator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_slot       slot_table [DEPTH];
    t_cfg        cfg_shadow;
    t_out_item   due_responses [$];

    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          config_writes = 0;
    int          cmd_count   [8];
    int          status_seen [8];
    int unsigned gap_max    = 4;
    int unsigned burst_max  = 3;
    int unsigned burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_id_bits();
        return clamp_to(cfg_shadow.id_bits, 1, 8);
    endfunction

    function automatic int unsigned eff_gen_bits();
        return clamp_to(cfg_shadow.gen_bits, 1, 32);
    endfunction

    function automatic logic [2:0] find_slot(input logic [7:0] grp, input logic [63:0] slt,
                                             output int unsigned idx);
        idx = 0;
        if (grp >= clamp_to(cfg_shadow.groups, 1, MAX_GROUPS)) return ST_BAD_GROUP;
        if (slt >= clamp_to(cfg_shadow.slots, 1, MAX_SLOTS)) return ST_BAD_SLOT;
        idx = grp * MAX_SLOTS + int'(slt);
        return ST_OK;
    endfunction

    function automatic t_out_item compute_slot_response(input t_in_item it);
        t_out_item   r;
        int unsigned idx;
        int unsigned ib;
        int unsigned gb;
        logic [63:0] tag_slot;
        logic [63:0] tag_gen;
        logic [63:0] h;
        logic [63:0] top;
        r   = '0;
        ib  = eff_id_bits();
        gb  = eff_gen_bits();
        case (it.command)
            CMD_TRANSLATE: begin
                tag_slot = it.address >> (ADDR_W - ib);
                tag_gen  = (it.address >> (ADDR_W - ib - gb)) & ((64'd1 << gb) - 64'd1);
                r.status = find_slot(it.group_index, tag_slot, idx);
                if (r.status == ST_OK && tag_gen[31:0] != slot_table[idx].slot_generation)
                    r.status = ST_BAD_GEN;
                if (r.status == ST_OK) begin
                    h   = (it.address & (ALL_ONES >> (ib + gb))) + slot_table[idx].offset_value;
                    top = h + 64'(it.access_size);
                    if (top < h) begin
                        r.status = ST_WRAP;
                    end else if (h < slot_table[idx].range_start
                                 || top > slot_table[idx].range_end) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.result_value = h;
                    end
                end
            end
            CMD_ADD: begin
                r.status = find_slot(it.group_index, 64'(it.slot_index), idx);
                if (r.status == ST_OK) begin
                    slot_table[idx].offset_value    = it.offset_value;
                    slot_table[idx].range_start     = it.range_start;
                    slot_table[idx].range_end       = it.range_end;
                    slot_table[idx].slot_generation = it.slot_generation;
                end
            end
            CMD_DELETE: begin
                r.status = find_slot(it.group_index, 64'(it.slot_index), idx);
                if (r.status == ST_OK) begin
                    slot_table[idx].range_start = '0;
                    slot_table[idx].range_end   = '0;
                end
            end
            CMD_CLEAR: begin
                foreach (slot_table[i]) slot_table[i] = '0;
            end
            CMD_SIZE: begin
                r.status = find_slot(it.group_index, 64'(it.slot_index), idx);
                if (r.status == ST_OK) begin
                    if (it.address < slot_table[idx].range_start
                        || it.address > slot_table[idx].range_end) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.result_value = slot_table[idx].range_end - it.address;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // -------------------------------------------------------------- helpers

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] tagged_address(input logic [7:0] slt,
                                                   input logic [31:0] gen,
                                                   input logic [63:0] low);
        int unsigned ib;
        int unsigned gb;
        ib = eff_id_bits();
        gb = eff_gen_bits();
        return (64'(slt) << (ADDR_W - ib))
             | ((64'(gen) & ((64'd1 << gb) - 64'd1)) << (ADDR_W - ib - gb))
             | (low & (ALL_ONES >> (ib + gb)));
    endfunction

    function automatic t_in_item mk_item(input logic [2:0] cmd, input logic [7:0] grp,
                                         input logic [7:0] slt, input logic [63:0] addr,
                                         input logic [31:0] size, input logic [63:0] off,
                                         input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [31:0] gen);
        t_in_item it;
        it.command         = cmd;
        it.group_index     = grp;
        it.slot_index      = slt;
        it.address         = addr;
        it.access_size     = size;
        it.offset_value    = off;
        it.range_start     = lo;
        it.range_end       = hi;
        it.slot_generation = gen;
        return it;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    // ------------------------------------------------------- result checker

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            status_seen[o_result.status]++;
            if (due_responses.size() == 0) begin
                note_mismatch("unexpected result, status", '0, 64'(o_result.status));
            end else begin
                want = due_responses.pop_front();
                if (o_result.status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(o_result.status));
                if (o_result.result_value !== want.result_value)
                    note_mismatch("result value", want.result_value, o_result.result_value);
            end
        end
    end

    // -------------------------------------------------------------- drivers

    task automatic pace_sender();
        int unsigned gap;
        if (gap_max == 0) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, gap_max);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, burst_max);
        end
    endtask

    task automatic issue_command(input t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        due_responses.push_back(compute_slot_response(it));
        cmd_count[it.command]++;
        pace_sender();
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (due_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (reg_idx)
            CFG_GROUPS:   cfg_shadow.groups   = value[2:0];
            CFG_SLOTS:    cfg_shadow.slots    = value[4:0];
            CFG_ID_BITS:  cfg_shadow.id_bits  = value[3:0];
            CFG_GEN_BITS: cfg_shadow.gen_bits = value[5:0];
            default: begin
            end
        endcase
        config_writes++;
    endtask

    task automatic apply_config(input logic [5:0] groups, input logic [5:0] slots,
                                input logic [5:0] id_bits, input logic [5:0] gen_bits);
        write_register(CFG_GROUPS, groups);
        write_register(CFG_SLOTS, slots);
        write_register(CFG_ID_BITS, id_bits);
        write_register(CFG_GEN_BITS, gen_bits);
    endtask

    // mostly well-formed commands aimed at slots that exist, with noise mixed in
    task automatic random_command(output t_in_item it);
        int unsigned pick;
        int unsigned ng;
        int unsigned slot_lim;
        int unsigned span;
        int unsigned r;
        logic [7:0]  grp;
        logic [7:0]  slt;
        logic [63:0] off;
        t_slot       ent;
        it = mk_item(3'($urandom), 8'($urandom), 8'($urandom), rand64(), $urandom,
                     rand64(), rand64(), rand64(), $urandom);
        pick     = $urandom_range(0, 99);
        ng       = clamp_to(cfg_shadow.groups, 1, MAX_GROUPS);
        slot_lim = clamp_to(cfg_shadow.slots, 1, MAX_SLOTS);
        if (pick < 50 && slot_lim > (1 << eff_id_bits()))
            slot_lim = 1 << eff_id_bits();
        grp = 8'($urandom_range(0, ng - 1));
        slt = 8'($urandom_range(0, slot_lim - 1));
        if ($urandom_range(0, 9) == 0) grp = 8'($urandom);
        if ($urandom_range(0, 9) == 0) slt = 8'($urandom);
        ent  = slot_table[(grp % MAX_GROUPS) * MAX_SLOTS + (slt % MAX_SLOTS)];
        span = (ent.range_end - ent.range_start > 64'h1_0000) ? 32'h1_0000
             : 32'(ent.range_end - ent.range_start);
        if (pick < 50) begin
            it.command     = CMD_TRANSLATE;
            it.group_index = grp;
            if ($urandom_range(0, 19) != 0)
                it.address = tagged_address(slt,
                    ($urandom_range(0, 9) == 0) ? $urandom : ent.slot_generation,
                    ent.range_start + 64'($urandom_range(0, span + 32)) - 64'd16
                    - ent.offset_value);
            r = $urandom_range(0, 99);
            if (r < 70)
                it.access_size = $urandom_range(0, 64);
            else if (r < 85)
                it.access_size = $urandom_range(0, span);
        end else if (pick < 65) begin
            it.command     = CMD_ADD;
            it.group_index = grp;
            it.slot_index  = slt;
            r = $urandom_range(0, 3);
            off = (r == 0) ? rand64()
                : (r == 1) ? ALL_ONES - 64'($urandom_range(0, 32'h1000))
                : 64'($urandom_range(0, 32'hFFFF));
            it.offset_value = off;
            if ($urandom_range(0, 7) != 0) begin
                it.range_start = off + 64'($urandom_range(0, 32'h1000));
                it.range_end   = it.range_start + 64'($urandom_range(0, 32'h4000));
            end
            if ($urandom_range(0, 7) != 0)
                it.slot_generation = $urandom & 32'((64'd1 << eff_gen_bits()) - 64'd1);
        end else if (pick < 77) begin
            it.command     = CMD_SIZE;
            it.group_index = grp;
            it.slot_index  = slt;
            if ($urandom_range(0, 9) != 0)
                it.address = ent.range_start + 64'($urandom_range(0, span + 32)) - 64'd16;
        end else if (pick < 83) begin
            it.command     = CMD_DELETE;
            it.group_index = grp;
            it.slot_index  = slt;
        end else if (pick < 85) begin
            it.command = CMD_CLEAR;
        end else if (pick < 88) begin
            it.command = 3'(CMD_SIZE + $urandom_range(1, 3));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        issue_command(mk_item(CMD_TRANSLATE, 8'd0, 8'd0, '0, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd0, 8'd0, ALL_ONES, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_SIZE, 8'd1, 8'd0, '0, '0, '0, '0, '0, '0));
    endtask

    task automatic test_translate_checks();
        apply_config(6'd4, 6'd10, 6'd4, 6'd8);
        issue_command(mk_item(CMD_ADD, 8'd2, 8'd3, '0, '0, 64'h1000, 64'h1800, 64'h2000,
                              32'h5A));
        issue_command(mk_item(CMD_TRANSLATE, 8'd2, 8'd0,
                              tagged_address(8'd3, 32'h5A, 64'h7FF), 32'd0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd2, 8'd0,
                              tagged_address(8'd3, 32'h5A, 64'h800), 32'h800, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd2, 8'd0,
                              tagged_address(8'd3, 32'h5A, 64'h800), 32'h801, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd2, 8'd0,
                              tagged_address(8'd3, 32'h5B, 64'h900), 32'd4, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd4, 8'd0,
                              tagged_address(8'd3, 32'h5A, 64'h900), 32'd4, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd2, 8'd0,
                              tagged_address(8'd15, 32'h5A, 64'h900), 32'd4, '0, '0, '0, '0));
        // offset near the top of the address space: wrap, then the largest fit
        issue_command(mk_item(CMD_ADD, 8'd3, 8'd9, '0, '0, 64'hFFFF_FFFF_FFFF_FF00, '0,
                              ALL_ONES, 32'hFF));
        issue_command(mk_item(CMD_TRANSLATE, 8'd3, 8'd0,
                              tagged_address(8'd9, 32'hFF, '0), 32'h100, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd3, 8'd0,
                              tagged_address(8'd9, 32'hFF, '0), 32'hFF, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'hFF, 8'hFF, ALL_ONES, 32'hFFFF_FFFF, ALL_ONES,
                              ALL_ONES, ALL_ONES, 32'hFFFF_FFFF));
        issue_command(mk_item(CMD_TRANSLATE, 8'd0, 8'd0, ALL_ONES, 32'hFFFF_FFFF, '0, '0, '0,
                              '0));
    endtask

    task automatic test_slot_commands();
        issue_command(mk_item(CMD_SIZE, 8'd2, 8'd3, 64'h1900, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_SIZE, 8'd2, 8'd3, 64'h17FF, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_SIZE, 8'd2, 8'd3, 64'h2001, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_SIZE, 8'd2, 8'd3, 64'h2000, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_DELETE, 8'd2, 8'd3, '0, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_SIZE, 8'd2, 8'd3, '0, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_ADD, 8'hFF, 8'd0, '0, '0, ALL_ONES, ALL_ONES, ALL_ONES,
                              32'hFFFF_FFFF));
        issue_command(mk_item(CMD_DELETE, 8'd0, 8'hFF, '0, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_SIZE, 8'd0, 8'd10, '0, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_CLEAR, 8'hFF, 8'hFF, ALL_ONES, '0, '0, '0, '0, '0));
        issue_command(mk_item(CMD_TRANSLATE, 8'd3, 8'd0,
                              tagged_address(8'd9, 32'hFF, '0), 32'd0, '0, '0, '0, '0));
        for (int k = 1; k <= 3; k++)
            issue_command(mk_item(3'(CMD_SIZE + k), 8'd2, 8'd3, rand64(), $urandom,
                                  rand64(), rand64(), rand64(), $urandom));
    endtask

    task automatic test_random_traffic();
        t_in_item it;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_config(6'd0, 6'd0, 6'd0, 6'd0);
                1: apply_config(6'd7, 6'd31, 6'd15, 6'd63);
                2: apply_config(6'd4, 6'd16, 6'd8, 6'd32);
                3: apply_config(6'd1, 6'd1, 6'd1, 6'd1);
                default: apply_config(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
            endcase
            gap_max    = (phase == 5) ? 0 : $urandom_range(2, 12);
            burst_max  = $urandom_range(0, 16);
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off until the table pipeline is empty
                if (n == PHASE_ITEMS / 2 && phase[0]) wait_until_drained();
                random_command(it);
                issue_command(it);
            end
        end
    endtask

    task automatic finish_run();
        int known;
        known = cmd_count[CMD_TRANSLATE] + cmd_count[CMD_ADD] + cmd_count[CMD_DELETE]
              + cmd_count[CMD_CLEAR] + cmd_count[CMD_SIZE];
        $display("summary: translate %0d, add %0d, delete %0d, clear %0d, size %0d, other %0d,",
                 cmd_count[CMD_TRANSLATE], cmd_count[CMD_ADD], cmd_count[CMD_DELETE],
                 cmd_count[CMD_CLEAR], cmd_count[CMD_SIZE],
                 cmd_count.sum() - known);
        $display("summary: %0d register writes; ok %0d, bad group %0d, bad slot %0d, gen %0d, %s",
                 config_writes, status_seen[ST_OK], status_seen[ST_BAD_GROUP],
                 status_seen[ST_BAD_SLOT], status_seen[ST_BAD_GEN],
                 $sformatf("wrap %0d, out of range %0d, mismatches %0d", status_seen[ST_WRAP],
                           status_seen[ST_RANGE], mismatches));
        if (mismatches == 0 && due_responses.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    endtask

    initial begin
        foreach (slot_table[i]) slot_table[i] = '0;
        foreach (cmd_count[i]) cmd_count[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        cfg_shadow = '{groups: 3'd1, slots: 5'd1, id_bits: 4'd1, gen_bits: 6'd8};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_translate_checks();
        test_slot_commands();
        test_random_traffic();
        wait_until_drained();
        finish_run();
    end

endmodule

// File: filelist.f
src/tast_pkg.sv
src/tast_ram.sv
src/tast_cfg.sv
src/tast_table.sv
src/tagged_address_slot_translator_unit.sv
sim/tb_top.sv
